[src/u8v_pkg.sv]
// Shared types, byte constants and helper functions for the UTF-8 stream validator.
// No dependencies; the classifier, tracker, top level and bench import this package.
package u8v_pkg;

  // Width of the count of continuation bytes a lead can open (up to five)
  localparam int unsigned PendW = 3;

  // Byte masks and patterns of the six-byte form
  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContPat  = 8'h80;
  localparam logic [7:0] Lead3    = 8'hE0;
  localparam logic [7:0] Lead4    = 8'hF0;
  localparam logic [7:0] Lead5    = 8'hF8;
  localparam logic [7:0] Lead6    = 8'hFC;

  // Classification of one raw byte, seen outside an open sequence
  typedef struct packed {
    logic             is_ascii;  // 00..7F, passes alone
    logic [PendW-1:0] need;      // continuation bytes a lead opens, 0 if none
    logic             bad;       // C0/C1 lead, stray continuation, FE or FF
  } byte_class_t;

  // Continuation byte test: 10xx xxxx
  function automatic logic is_cont(input logic [7:0] b);
    return (b & ContMask) == ContPat;
  endfunction

  // Overlong test on a lead and its first continuation byte
  function automatic logic overlong_second(input logic [7:0] lead, input logic [7:0] b);
    logic res;
    res = 1'b0;
    if (lead == Lead3) res = (b & Lead3) == ContPat;
    if (lead == Lead4) res = (b & Lead4) == ContPat;
    if (lead == Lead5) res = (b & Lead5) == ContPat;
    if (lead == Lead6) res = (b & Lead6) == ContPat;
    return res;
  endfunction

endpackage

[src/u8v_if.sv]
// Valid/ready channel interfaces: raw bytes in, verdicts out.
// Depends on nothing; carries plain logic payloads.
interface u8v_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8v_res_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink (input valid, input valid_res, output ready);
endinterface

[src/u8v_byte_class.sv]
// Byte classifier: sorts a raw byte into ASCII, lead of a given length or error.
// Depends on u8v_pkg for byte_class_t.
module u8v_byte_class
  import u8v_pkg::*;
(
  input  logic [7:0]  data_byte,
  output byte_class_t cls
);

  // Decode the byte ranges of the six-byte form
  always_comb begin
    cls = '{is_ascii: 1'b0, need: '0, bad: 1'b0};
    case (data_byte) inside
      [8'h00:8'h7F]: cls.is_ascii = 1'b1;
      [8'hC0:8'hC1]: begin
        cls.need = PendW'(1);
        cls.bad  = 1'b1;
      end
      [8'hC2:8'hDF]: cls.need = PendW'(1);
      [8'hE0:8'hEF]: cls.need = PendW'(2);
      [8'hF0:8'hF7]: cls.need = PendW'(3);
      [8'hF8:8'hFB]: cls.need = PendW'(4);
      [8'hFC:8'hFD]: cls.need = PendW'(5);
      default: cls.bad = 1'b1;  // stray continuation, FE or FF
    endcase
  end

endmodule

[src/u8v_seq_check.sv]
// Sequence tracker: holds the open-sequence state and sticky error of one string.
// Depends on u8v_pkg for byte_class_t and the continuation/overlong helpers.
module u8v_seq_check
  import u8v_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  byte_class_t cls,
  output logic        valid_res
);

  logic [PendW-1:0] bytes_pending, bytes_pending_next;
  logic [7:0]       lead_value, lead_value_next;
  logic             expect_second, expect_second_next;
  logic             error_seen, error_seen_next;

  // Work out the state after this byte and the verdict if it ends the string
  always_comb begin
    bytes_pending_next = bytes_pending;
    lead_value_next    = lead_value;
    expect_second_next = expect_second;
    error_seen_next    = error_seen;
    if (bytes_pending != '0) begin
      if (!is_cont(data_byte)) error_seen_next = 1'b1;
      if (expect_second && overlong_second(lead_value, data_byte)) error_seen_next = 1'b1;
      expect_second_next = 1'b0;
      bytes_pending_next = bytes_pending - PendW'(1);
    end else if (!cls.is_ascii) begin
      if (cls.bad) error_seen_next = 1'b1;
      if (cls.need != '0) begin
        bytes_pending_next = cls.need;
        lead_value_next    = data_byte;
        expect_second_next = 1'b1;
      end
    end
    valid_res = !(error_seen_next || (bytes_pending_next != '0));
  end

  // Advance on each byte; clear everything once the string ends
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      lead_value    <= '0;
      expect_second <= 1'b0;
      error_seen    <= 1'b0;
    end else if (advance) begin
      if (last_byte) begin
        bytes_pending <= '0;
        lead_value    <= '0;
        expect_second <= 1'b0;
        error_seen    <= 1'b0;
      end else begin
        bytes_pending <= bytes_pending_next;
        lead_value    <= lead_value_next;
        expect_second <= expect_second_next;
        error_seen    <= error_seen_next;
      end
    end
  end

endmodule

[src/utf8_stream_validator_unit.sv]
// UTF-8 stream validator (old six-byte form). Takes one byte per request on
// `bytes`, with last_byte marking the end of a string, and returns one verdict
// request on `verdict` for each string: valid_res is 1 when the whole string
// was well-formed. A byte is accepted every clock while the verdict side keeps
// up; a verdict passes through the input register and then the result register,
// around the combinational check logic.
// Ready falls only while a finished verdict waits and another last byte needs it.
// Depends on u8v_pkg, u8v_if, u8v_byte_class and u8v_seq_check.
module utf8_stream_validator_unit
  import u8v_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  u8v_byte_if.sink        bytes,
  u8v_res_if.source       verdict
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_res;
  logic        out_free;
  logic        advance;
  logic        res_comb;
  byte_class_t cls;

  // Hand on the held byte when the result slot can take what it produces
  assign out_free    = !out_valid || verdict.ready;
  assign advance     = in_valid && (!in_last || out_free);
  assign bytes.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.ready) begin
      in_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      in_byte <= bytes.data_byte;
      in_last <= bytes.last_byte;
    end
  end

  u8v_byte_class u_class (
    .data_byte (in_byte),
    .cls       (cls)
  );

  u8v_seq_check u_check (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .data_byte (in_byte),
    .last_byte (in_last),
    .cls       (cls),
    .valid_res (res_comb)
  );

  // Result register: load a verdict on the last byte, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_res <= res_comb;
    end
  end

  assign verdict.valid     = out_valid;
  assign verdict.valid_res = out_res;

endmodule

[src/u8v_checker.sv]
// Port-level checks for the validator: verdict hold, reset and string accounting.
// Depends only on the top level's ports; bound to utf8_stream_validator_unit below.
module u8v_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_res
);

  logic [1:0] strings_open;
  logic       last_taken;
  logic       res_taken;

  assign last_taken = in_valid && in_ready && in_last;
  assign res_taken  = out_valid && out_ready;

  // Count strings whose last byte is in but whose verdict is not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      strings_open <= '0;
    end else begin
      strings_open <= strings_open + {1'b0, last_taken} - {1'b0, res_taken};
    end
  end

  // A stalled verdict holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("verdict changed while stalled");

  // No verdict straight after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("verdict present after reset");

  // Every verdict belongs to a finished string
  a_owner: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> strings_open != 2'd0)
    else $error("verdict without a finished string");

  // Only the input and result registers can hold finished strings
  a_depth: assert property (@(posedge clk) disable iff (rst)
    strings_open != 2'd3)
    else $error("too many strings awaiting a verdict");

endmodule

bind utf8_stream_validator_unit u8v_checker u_u8v_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (bytes.valid),
  .in_ready  (bytes.ready),
  .in_last   (bytes.last_byte),
  .out_valid (verdict.valid),
  .out_ready (verdict.ready),
  .out_res   (verdict.valid_res)
);

[test/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for utf8_stream_validator_unit: byte requests in, verdicts out.
// Depends on u8v_pkg, u8v_if and the validator RTL.
module tb_top;
  import u8v_pkg::*;

  // Lowest legal second byte after the overlong-prone leads
  localparam logic [7:0] MinSec3 = 8'hA0;
  localparam logic [7:0] MinSec4 = 8'h90;
  localparam logic [7:0] MinSec5 = 8'h88;
  localparam logic [7:0] MinSec6 = 8'h84;

  localparam int unsigned RandomBytes   = 1000;
  localparam int unsigned MaxGap        = 11;
  localparam int unsigned GapPhaseBytes = 150;
  localparam int unsigned GapPhaseVerds = 30;
  localparam int unsigned HoldOffAt     = 10;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned CycleLimit    = 200000;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned hold;
  } byte_req_t;

  logic clk;
  logic rst;

  u8v_byte_if byte_ch ();
  u8v_res_if  verdict_ch ();

  utf8_stream_validator_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .verdict (verdict_ch)
  );

  byte_req_t   byte_plan_q[$];
  logic [7:0]  text_q[$];
  logic        verdict_q[$];
  int unsigned planned;
  int unsigned bytes_taken;
  int unsigned verdicts_seen;
  int unsigned strings_good;
  int unsigned strings_bad;
  int unsigned mismatches;
  int unsigned cycle_count;

  // Shadow state of the validator
  logic [PendW-1:0] open_left;
  logic [7:0]       open_lead;
  logic             at_second;
  logic             str_broken;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the shadow state by one accepted byte; queue a verdict on the last byte
  function automatic void scan_utf8_byte(input logic [7:0] b, input logic last);
    logic [PendW-1:0] need;
    logic [7:0]       floor_b;
    logic             ok;
    need = '0;
    if (open_left != 0) begin
      case (open_lead)
        Lead3:   floor_b = MinSec3;
        Lead4:   floor_b = MinSec4;
        Lead5:   floor_b = MinSec5;
        Lead6:   floor_b = MinSec6;
        default: floor_b = 8'h00;
      endcase
      // a wrong byte still uses up its slot in the sequence
      if ((b & ContMask) != ContPat) str_broken = 1'b1;
      if (at_second && b < floor_b) str_broken = 1'b1;
      at_second = 1'b0;
      open_left = open_left - 1'b1;
    end else begin
      case (b) inside
        8'b0???????: ;
        8'b10??????: str_broken = 1'b1;
        8'b110?????: begin
          need = PendW'(1);
          if (b[7:1] == 7'b1100000) str_broken = 1'b1;
        end
        8'b1110????: need = PendW'(2);
        8'b11110???: need = PendW'(3);
        8'b111110??: need = PendW'(4);
        8'b1111110?: need = PendW'(5);
        default:     str_broken = 1'b1;
      endcase
      if (need != 0) begin
        open_left = need;
        open_lead = b;
        at_second = 1'b1;
      end
    end
    if (last) begin
      // an open sequence at the end means the string was cut short
      ok = !(str_broken || open_left != 0);
      verdict_q.push_back(ok);
      if (ok) strings_good++;
      else strings_bad++;
      open_left  = '0;
      open_lead  = '0;
      at_second  = 1'b0;
      str_broken = 1'b0;
    end
  endfunction

  function automatic logic [7:0] cont_byte();
    return ContPat | 8'($urandom_range(0, 63));
  endfunction

  // Append one well-formed character of len bytes with random content
  function automatic void add_char(input int unsigned len);
    logic [7:0] first;
    logic [7:0] low_sec;
    low_sec = ContPat;
    case (len)
      2: first = 8'($urandom_range(8'hC2, 8'hDF));
      3: begin
        first = 8'($urandom_range(Lead3, 8'hEF));
        if (first == Lead3) low_sec = MinSec3;
      end
      4: begin
        first = 8'($urandom_range(Lead4, 8'hF7));
        if (first == Lead4) low_sec = MinSec4;
      end
      5: begin
        first = 8'($urandom_range(Lead5, 8'hFB));
        if (first == Lead5) low_sec = MinSec5;
      end
      6: begin
        first = 8'($urandom_range(Lead6, 8'hFD));
        if (first == Lead6) low_sec = MinSec6;
      end
      default: first = 8'($urandom_range(0, 127));
    endcase
    text_q.push_back(first);
    for (int i = 1; i < len; i++)
      text_q.push_back(i == 1 ? 8'($urandom_range(low_sec, 8'hBF)) : cont_byte());
  endfunction

  // Append a character whose second byte sits on the overlong boundary
  function automatic void add_edge_char();
    logic [7:0]  first;
    logic [7:0]  floor_b;
    int unsigned len;
    case ($urandom_range(0, 3))
      0: begin first = Lead3; floor_b = MinSec3; len = 3; end
      1: begin first = Lead4; floor_b = MinSec4; len = 4; end
      2: begin first = Lead5; floor_b = MinSec5; len = 5; end
      default: begin first = Lead6; floor_b = MinSec6; len = 6; end
    endcase
    text_q.push_back(first);
    text_q.push_back($urandom_range(0, 1) ? floor_b : floor_b - 8'd1);
    repeat (len - 2) text_q.push_back(cont_byte());
  endfunction

  // Append a character that is then cut short or has one trailing byte spoiled
  function automatic void add_broken_char();
    int unsigned len;
    int unsigned drop;
    len = $urandom_range(2, 6);
    add_char(len);
    if ($urandom_range(0, 1)) begin
      drop = $urandom_range(1, len - 1);
      repeat (drop) void'(text_q.pop_back());
    end else begin
      text_q[text_q.size() - $urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
    end
  endfunction

  // Move the built string into the plan, marking its final byte
  function automatic void queue_string();
    byte_req_t req;
    foreach (text_q[i]) begin
      req.data = text_q[i];
      req.last = (i == text_q.size() - 1);
      req.hold = ((planned / GapPhaseBytes) % 2 == 1) ? $urandom_range(0, MaxGap) : 0;
      byte_plan_q.push_back(req);
      planned++;
    end
    text_q.delete();
  endfunction

  // Driver: offer queued bytes, holding each until it is taken
  byte_req_t cur_req;
  logic      staged;

  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      staged = 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        scan_utf8_byte(byte_ch.data_byte, byte_ch.last_byte);
        bytes_taken++;
      end
      if (!(byte_ch.valid && !byte_ch.ready)) begin
        if (!staged && byte_plan_q.size() != 0) begin
          cur_req = byte_plan_q.pop_front();
          staged  = 1'b1;
        end
        if (staged && cur_req.hold != 0) begin
          cur_req.hold--;
          byte_ch.valid <= 1'b0;
        end else if (staged) begin
          byte_ch.data_byte <= cur_req.data;
          byte_ch.last_byte <= cur_req.last;
          byte_ch.valid     <= 1'b1;
          staged = 1'b0;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each verdict against the oldest expectation and pace ready
  int unsigned stall_left;

  always @(posedge clk) begin
    if (rst) begin
      verdict_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (verdict_ch.valid && verdict_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict %0b arrived with none expected", $time,
                   verdict_ch.valid_res);
          mismatches++;
        end else if (verdict_q[0] !== verdict_ch.valid_res) begin
          $display("%0t: valid_res expected %0b, got %0b", $time, verdict_q[0],
                   verdict_ch.valid_res);
          mismatches++;
          void'(verdict_q.pop_front());
        end else begin
          void'(verdict_q.pop_front());
        end
        verdicts_seen++;
        // hold off once for a long stretch so the block backs up
        if (verdicts_seen == HoldOffAt) stall_left = HoldOffCycles;
        else if ((verdicts_seen / GapPhaseVerds) % 2 == 1)
          stall_left = $urandom_range(0, MaxGap);
        else stall_left = 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      verdict_ch.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) cycle_count++;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("%0t: timed out with %0d verdicts outstanding", $time, verdict_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus: directed strings, then random strings, then drain and report
  initial begin
    int unsigned directed_n;
    int unsigned kind;
    rst = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.last_byte = 1'b0;
    verdict_ch.ready  = 1'b0;
    open_left  = '0;
    open_lead  = '0;
    at_second  = 1'b0;
    str_broken = 1'b0;

    // ASCII extremes, stray continuation, FF, FE, C1 lead
    text_q = '{8'h00, 8'h7F};                          queue_string();
    text_q = '{8'hBF};                                 queue_string();
    text_q = '{8'hFF};                                 queue_string();
    text_q = '{8'hFE};                                 queue_string();
    text_q = '{8'hC1, 8'h80};                          queue_string();
    // overlong three and four byte forms, shortest legal six byte form
    text_q = '{Lead3, 8'h9F, 8'hBF};                   queue_string();
    text_q = '{Lead4, 8'h8F, 8'h80, 8'h80};            queue_string();
    text_q = '{Lead6, MinSec6, 8'h80, 8'h80, 8'h80, 8'hBF}; queue_string();
    // ASCII inside a sequence is consumed, not read as a new lead
    text_q = '{8'hE1, 8'h41, 8'h80};                   queue_string();
    // sequence cut short by the end of the string
    text_q = '{8'hC2};                                 queue_string();
    directed_n = planned;

    // Mostly well-formed strings, with edge, broken and noise characters mixed in
    while (planned < directed_n + RandomBytes) begin
      repeat ($urandom_range(1, 6)) begin
        kind = $urandom_range(0, 99);
        if (kind < 70) add_char($urandom_range(1, 6));
        else if (kind < 80) add_edge_char();
        else if (kind < 90) add_broken_char();
        else text_q.push_back(8'($urandom_range(0, 255)));
      end
      queue_string();
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken < planned || verdict_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Checked %0d bytes in %0d strings: %0d well-formed, %0d rejected.",
             bytes_taken, strings_good + strings_bad, strings_good, strings_bad);
    $display("Verdicts seen %0d, mismatches %0d, one %0d-cycle back-pressure stretch.",
             verdicts_seen, mismatches, HoldOffCycles);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
src/u8v_pkg.sv
src/u8v_if.sv
src/u8v_byte_class.sv
src/u8v_seq_check.sv
src/utf8_stream_validator_unit.sv
src/u8v_checker.sv
test/tb_top.sv
